### design/kgt_pkg.sv
// Shared types and constants for the keyed grant table.
// No dependencies; imported by every module of the block.
`default_nettype none
package kgt_pkg;

    typedef enum logic [2:0] {
        OP_ALLOW  = 3'd0,
        OP_REVOKE = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_QUERY  = 3'd3,
        OP_CHECK  = 3'd4,
        OP_STATS  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    localparam logic CFG_MASTER = 1'b0;
    localparam logic CFG_FREQ   = 1'b1;

    // ceil(2^85 / 1e9): (p >> 9) times this, shifted down by 76, is p / 1e9
    localparam logic [55:0] NS_RECIP   = 56'd38685626227668134;
    localparam logic [31:0] FREQ_RESET = 32'd19200000;

    // Command word held for the whole scan.
    typedef struct packed {
        t_op         op;
        logic [31:0] uid;
        logic [31:0] flags;
        logic [63:0] tok;
        logic [63:0] now;
    } t_cmd;

    // Scan word passed from cell to cell.
    typedef struct packed {
        logic        vld;
        logic        stop;
        logic        found;
        logic        tok_ok;
        logic        free_vld;
        logic [31:0] flags;
    } t_wave;

    // Entry write broadcast at the end of an allow.
    typedef struct packed {
        logic        en;
        logic [31:0] user;
        logic [31:0] flags;
        logic [63:0] tok;
        logic [63:0] exp;
    } t_wr;

endpackage
`default_nettype wire

### design/kgt_expiry.sv
// Lifetime conversion: (ttl * freq mod 2^64) / 1e9, sequential.
// Two 32x32 partial products, then four more against a fixed reciprocal.
`default_nettype none
module kgt_expiry import kgt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [63:0] i_ttl,
    input  wire logic [31:0] i_freq,
    output logic             o_done,
    output logic [63:0]      o_quot
);

    logic [63:0]  r_ttl;
    logic [31:0]  r_freq;
    logic [63:0]  r_lo;
    logic [31:0]  r_hi;
    logic [63:0]  r_q;
    logic [111:0] r_acc;
    logic [2:0]   r_phase;
    logic         r_busy;
    logic         r_done;

    logic [54:0]  y;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  pp;
    logic [111:0] pp_sh;

    // exact for every 64-bit product: error term stays below 2^76
    assign y = r_q[63:9];

    always_comb begin
        mul_a = y[31:0];
        mul_b = NS_RECIP[31:0];
        if (r_phase == 3'd5 || r_phase == 3'd6) mul_a = {9'd0, y[54:32]};
        if (r_phase == 3'd4 || r_phase == 3'd6) mul_b = {8'd0, NS_RECIP[55:32]};
    end

    assign pp = mul_a * mul_b;

    always_comb begin
        unique case (r_phase)
            3'd4, 3'd5: pp_sh = {16'd0, pp, 32'd0};
            3'd6:       pp_sh = {pp[47:0], 64'd0};
            default:    pp_sh = {48'd0, pp};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= '0;
        end else if (i_go) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_phase <= '0;
        end else if (r_busy) begin
            r_phase <= r_phase + 3'd1;
            if (r_phase == 3'd6) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_ttl  <= i_ttl;
            r_freq <= i_freq;
        end else if (r_busy) begin
            if (r_phase == 3'd0) begin
                r_lo <= r_ttl[31:0] * r_freq;
            end else if (r_phase == 3'd1) begin
                r_hi <= 32'(r_ttl[63:32] * r_freq);
            end else if (r_phase == 3'd2) begin
                r_q   <= r_lo + {r_hi, 32'd0};
                r_acc <= '0;
            end else begin
                r_acc <= r_acc + pp_sh;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = {28'd0, r_acc[111:76]};

endmodule
`default_nettype wire

### design/kgt_cell.sv
// One table entry plus its stage of the scan chain.
// Depends on kgt_pkg for the command, scan and write words.
`default_nettype none
module kgt_cell import kgt_pkg::*; #(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic [CW-1:0] i_n,
    input  wire t_wave         i_wave,
    input  wire logic [IW-1:0] i_free_idx,
    input  wire logic [CW-1:0] i_live,
    input  wire logic          i_clr,
    input  wire t_wr           i_wr,
    input  wire logic [IW-1:0] i_wr_idx,
    output t_wave              o_wave,
    output logic [IW-1:0]      o_free_idx,
    output logic [CW-1:0]      o_live
);

    logic [31:0]   r_user;
    logic [31:0]   r_flags;
    logic [63:0]   r_tok;
    logic [63:0]   r_exp;
    logic          r_act;
    t_wave         r_wave;
    logic [IW-1:0] r_free_idx;
    logic [CW-1:0] r_live;

    logic [31:0]   n_flags;
    logic [63:0]   n_tok;
    logic          n_act;
    t_wave         n_wave;
    logic [IW-1:0] n_free_idx;
    logic [CW-1:0] n_live;

    logic in_use, hit, expd;

    assign in_use = i_wave.vld && (CW'(IDX) < i_n);
    assign hit    = in_use && r_act && (r_user == i_cmd.uid);
    assign expd   = (r_exp != 64'd0) && (i_cmd.now > r_exp);

    always_comb begin
        n_flags    = r_flags;
        n_tok      = r_tok;
        n_act      = r_act;
        n_wave     = i_wave;
        n_free_idx = i_free_idx;
        n_live     = i_live;
        unique case (i_cmd.op)
            OP_ALLOW: begin
                if (hit && !i_wave.stop) begin
                    n_flags      = r_flags | i_cmd.flags;
                    if (i_cmd.tok != 64'd0) n_tok = i_cmd.tok;
                    n_wave.stop  = 1'b1;
                    n_wave.found = 1'b1;
                end else if (in_use && !r_act && !i_wave.free_vld) begin
                    n_wave.free_vld = 1'b1;
                    n_free_idx      = IW'(IDX);
                end
            end
            OP_REVOKE: begin
                if (hit) begin
                    n_act        = 1'b0;
                    n_wave.found = 1'b1;
                end
            end
            OP_QUERY: begin
                if (hit && !i_wave.stop) begin
                    if (expd) begin
                        n_act = 1'b0;
                    end else begin
                        n_wave.flags = r_flags;
                        n_wave.stop  = 1'b1;
                    end
                end
            end
            OP_CHECK: begin
                if (hit && !i_wave.stop) begin
                    n_wave.stop = 1'b1;
                    if (expd) n_act = 1'b0;
                    else n_wave.tok_ok = (r_tok == i_cmd.tok);
                end
            end
            OP_STATS: begin
                if (in_use && r_act && !expd) n_live = i_live + CW'(1);
            end
            default: ;
        endcase
        // clear and fill happen only after the scan, never with it
        if (i_clr) begin
            n_act = 1'b0;
        end else if (i_wr.en && i_wr_idx == IW'(IDX)) begin
            n_act   = 1'b1;
            n_flags = i_wr.flags;
            n_tok   = i_wr.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_wave <= '0;
        end else begin
            r_act  <= n_act;
            r_wave <= n_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags    <= n_flags;
        r_tok      <= n_tok;
        r_free_idx <= n_free_idx;
        r_live     <= n_live;
        if (i_wr.en && i_wr_idx == IW'(IDX)) begin
            r_user <= i_wr.user;
            r_exp  <= i_wr.exp;
        end
    end

    assign o_wave     = r_wave;
    assign o_free_idx = r_free_idx;
    assign o_live     = r_live;

endmodule
`default_nettype wire

### design/keyed_grant_table_with_expiry.sv
// Top level of the keyed grant table: cell chain, lifetime unit, sequencer.
// Depends on kgt_pkg, kgt_cell and kgt_expiry.
//
// Each operation sends one scan word down a chain of TABLE_ENTRIES cells,
// one cell per cycle; the last cell's word is captured in r_res and the
// sequencer goes through S_FIN to the o_valid strobe. An allow also waits
// for the lifetime unit (two multiply steps, a sum step and four reciprocal
// steps). busy is high from the accepting edge until the result strobe; a
// new start is taken in the strobe cycle. o_valid is high for one cycle and
// cannot be held off. A check_token that hits the master key still runs the
// scan but touches no entry.
`default_nettype none
module keyed_grant_table_with_expiry import kgt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic [2:0]  i_operation,
    input  wire logic [31:0] i_user_id,
    input  wire logic [31:0] i_grant_flags,
    input  wire logic [63:0] i_token,
    input  wire logic [63:0] i_ttl_ns,
    input  wire logic [63:0] i_now,
    output logic             o_valid,
    output logic             o_status,
    output logic [31:0]      o_flags_out,
    output logic             o_token_ok,
    output logic [31:0]      o_allow_total,
    output logic [31:0]      o_deny_total,
    output logic [4:0]       o_live_entries
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_state        r_state, n_state;
    t_cmd          r_cmd;
    logic          r_ttl_nz;
    logic [63:0]   r_master;
    logic [31:0]   r_freq;
    logic [CW-1:0] r_n;
    logic [31:0]   r_allow, r_deny;
    t_wave         r_launch;
    logic          r_scan_done;
    t_wave         r_res;
    logic [IW-1:0] r_res_free;
    logic [CW-1:0] r_res_live;
    logic          r_valid, r_status, r_tok_ok;
    logic [31:0]   r_flags_o, r_atot, r_dtot;
    logic [4:0]    r_live_o;

    t_wave         w_wave [TABLE_ENTRIES+1];
    logic [IW-1:0] w_free [TABLE_ENTRIES+1];
    logic [CW-1:0] w_live [TABLE_ENTRIES+1];

    logic          accept, mhit, exp_done, full, alloc_new, alloc_free, fail, clr;
    logic [63:0]   quot;
    t_wr           wr;
    logic [IW-1:0] wr_idx;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign mhit   = (t_op'(i_operation) == OP_CHECK) && (r_master != 64'd0)
                    && (i_token == r_master);

    assign w_wave[0] = r_launch;
    assign w_free[0] = '0;
    assign w_live[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        kgt_cell #(.IDX(g), .IW(IW), .CW(CW)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (r_cmd),
            .i_n        (r_n),
            .i_wave     (w_wave[g]),
            .i_free_idx (w_free[g]),
            .i_live     (w_live[g]),
            .i_clr      (clr),
            .i_wr       (wr),
            .i_wr_idx   (wr_idx),
            .o_wave     (w_wave[g+1]),
            .o_free_idx (w_free[g+1]),
            .o_live     (w_live[g+1])
        );
    end

    kgt_expiry u_expiry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept),
        .i_ttl   (i_ttl_ns),
        .i_freq  (r_freq),
        .o_done  (exp_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        full       = (r_n == CW'(TABLE_ENTRIES));
        alloc_new  = !r_res.found && !full;
        alloc_free = !r_res.found && full && r_res.free_vld;
        fail       = !r_res.found && full && !r_res.free_vld;
        clr        = 1'b0;
        wr         = '0;
        wr.user    = r_cmd.uid;
        wr.flags   = r_cmd.flags;
        wr.tok     = r_cmd.tok;
        wr.exp     = r_ttl_nz ? (r_cmd.now + quot) : 64'd0;
        wr_idx     = alloc_new ? IW'(r_n) : r_res_free;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_scan_done && (r_cmd.op != OP_ALLOW || exp_done)) n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
                clr     = (r_cmd.op == OP_CLEAR);
                wr.en   = (r_cmd.op == OP_ALLOW) && (alloc_new || alloc_free);
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master    <= '0;
            r_freq      <= FREQ_RESET;
            r_n         <= '0;
            r_allow     <= '0;
            r_deny      <= '0;
            r_launch    <= '0;
            r_scan_done <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MASTER) r_master <= i_cfg_data;
                else                         r_freq   <= i_cfg_data[31:0];
            end
            r_valid  <= (r_state == S_FIN);
            if (accept) begin
                r_launch    <= '{vld: 1'b1, stop: mhit, found: 1'b0, tok_ok: mhit,
                                 free_vld: 1'b0, flags: 32'd0};
                r_scan_done <= 1'b0;
            end else begin
                r_launch <= '0;
                if (w_wave[TABLE_ENTRIES].vld) r_scan_done <= 1'b1;
            end
            if (r_state == S_FIN) begin
                if (clr) r_n <= '0;
                else if (r_cmd.op == OP_ALLOW && alloc_new) r_n <= r_n + CW'(1);
                if (r_cmd.op == OP_QUERY) begin
                    if (r_res.flags != 32'd0) r_allow <= r_allow + 32'd1;
                    else                      r_deny  <= r_deny + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= '{op: t_op'(i_operation), uid: i_user_id, flags: i_grant_flags,
                          tok: i_token, now: i_now};
            r_ttl_nz <= (i_ttl_ns != 64'd0);
        end
        if (w_wave[TABLE_ENTRIES].vld) begin
            r_res      <= w_wave[TABLE_ENTRIES];
            r_res_free <= w_free[TABLE_ENTRIES];
            r_res_live <= w_live[TABLE_ENTRIES];
        end
        if (r_state == S_FIN) begin
            r_status  <= ((r_cmd.op == OP_ALLOW) && fail)
                         || ((r_cmd.op == OP_REVOKE) && !r_res.found);
            r_flags_o <= (r_cmd.op == OP_QUERY) ? r_res.flags : 32'd0;
            r_tok_ok  <= (r_cmd.op == OP_CHECK) && r_res.tok_ok;
            r_atot    <= (r_cmd.op == OP_STATS) ? r_allow : 32'd0;
            r_dtot    <= (r_cmd.op == OP_STATS) ? r_deny : 32'd0;
            r_live_o  <= (r_cmd.op == OP_STATS) ? 5'(r_res_live) : 5'd0;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_flags_out    = r_flags_o;
    assign o_token_ok     = r_tok_ok;
    assign o_allow_total  = r_atot;
    assign o_deny_total   = r_dtot;
    assign o_live_entries = r_live_o;

`ifndef SYNTHESIS
    a_fin_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_valid)
        else $error("result strobe missing after finish");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accepted start");
    a_tok_only_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_ok) |-> (r_cmd.op == OP_CHECK))
        else $error("token_ok on non-check operation");
    a_flags_only_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_flags_out != 32'd0) |-> (r_cmd.op == OP_QUERY))
        else $error("flags_out on non-query operation");
`endif

endmodule
`default_nettype wire

### test/keyed_grant_table_with_expiry_tb.sv
// Testbench for the keyed grant table: directed and random command words,
// checked against an in-bench table predictor. Depends on kgt_pkg and the RTL.
`default_nettype none
module keyed_grant_table_with_expiry_tb;
    import kgt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          N_SLOTS    = 16;
    localparam int          MAX_CYCLES = 400000;
    localparam logic [63:0] NS_SEC     = 64'd1000000000;
    localparam logic [2:0]  OP_SPARE_LO = 3'd6;
    localparam logic [2:0]  OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        status;
        logic [31:0] flags;
        logic        tok_ok;
        logic [31:0] allow_tot;
        logic [31:0] deny_tot;
        logic [4:0]  live;
    } t_grant_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [63:0] i_cfg_data = '0;
    logic [2:0]  i_operation = '0;
    logic [31:0] i_user_id = '0;
    logic [31:0] i_grant_flags = '0;
    logic [63:0] i_token = '0;
    logic [63:0] i_ttl_ns = '0;
    logic [63:0] i_now = '0;
    logic        o_valid;
    logic        o_status;
    logic [31:0] o_flags_out;
    logic        o_token_ok;
    logic [31:0] o_allow_total;
    logic [31:0] o_deny_total;
    logic [4:0]  o_live_entries;

    keyed_grant_table_with_expiry #(.TABLE_ENTRIES(N_SLOTS)) DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0] pm_master;
    logic [31:0] pm_freq;
    logic [31:0] tbl_user [N_SLOTS];
    logic [31:0] tbl_flags [N_SLOTS];
    logic [63:0] tbl_token [N_SLOTS];
    logic [63:0] tbl_expiry [N_SLOTS];
    logic        tbl_active [N_SLOTS];
    int          tbl_used;
    logic [31:0] hits_allow, hits_deny;

    t_grant_res  pending_results[$];
    int          errors = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    logic [63:0] clock_now = 64'd1000;
    logic [31:0] uid_pool [6];
    logic [63:0] tok_pool [4];

    function automatic bit is_stale(int i, logic [63:0] now);
        return tbl_expiry[i] != 0 && now > tbl_expiry[i];
    endfunction

    task automatic grant_table_step(input logic [2:0] op, input logic [31:0] uid,
                                    input logic [31:0] gfl, input logic [63:0] tok,
                                    input logic [63:0] ttl, input logic [63:0] now);
        t_grant_res r;
        int          n, slot;
        bit          done, have;
        logic [63:0] prod;
        r = '0;
        n = tbl_used;
        done = 0;
        case (op)
            OP_ALLOW: begin
                for (int i = 0; i < n; i++) begin
                    if (tbl_active[i] && tbl_user[i] == uid) begin
                        tbl_flags[i] |= gfl;
                        if (tok != 0) tbl_token[i] = tok;
                        done = 1;
                        break;
                    end
                end
                if (!done) begin
                    have = 0;
                    slot = 0;
                    if (n >= N_SLOTS) begin
                        for (int i = 0; i < n; i++) begin
                            if (!tbl_active[i]) begin
                                slot = i;
                                have = 1;
                                break;
                            end
                        end
                    end else begin
                        slot = n;
                        tbl_used = n + 1;
                        have = 1;
                    end
                    if (!have) begin
                        r.status = 1'b1;
                    end else begin
                        tbl_user[slot] = uid;
                        tbl_flags[slot] = gfl;
                        tbl_token[slot] = tok;
                        tbl_expiry[slot] = '0;
                        if (ttl != 0) begin
                            prod = ttl * {32'd0, pm_freq};
                            tbl_expiry[slot] = now + prod / NS_SEC;
                        end
                        tbl_active[slot] = 1'b1;
                    end
                end
            end
            OP_REVOKE: begin
                r.status = 1'b1;
                for (int i = 0; i < n; i++) begin
                    if (tbl_active[i] && tbl_user[i] == uid) begin
                        tbl_active[i] = 1'b0;
                        r.status = 1'b0;
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < N_SLOTS; i++) tbl_active[i] = 1'b0;
                tbl_used = 0;
            end
            OP_QUERY: begin
                for (int i = 0; i < n; i++) begin
                    if (!tbl_active[i] || tbl_user[i] != uid) continue;
                    if (is_stale(i, now)) begin
                        tbl_active[i] = 1'b0;
                        continue;
                    end
                    r.flags = tbl_flags[i];
                    break;
                end
                if (r.flags != 0) hits_allow++;
                else hits_deny++;
            end
            OP_CHECK: begin
                if (pm_master != 0 && tok == pm_master) begin
                    r.tok_ok = 1'b1;
                end else begin
                    for (int i = 0; i < n; i++) begin
                        if (!tbl_active[i] || tbl_user[i] != uid) continue;
                        if (is_stale(i, now)) tbl_active[i] = 1'b0;
                        else if (tbl_token[i] == tok) r.tok_ok = 1'b1;
                        break;
                    end
                end
            end
            OP_STATS: begin
                r.allow_tot = hits_allow;
                r.deny_tot = hits_deny;
                for (int i = 0; i < n; i++)
                    if (tbl_active[i] && !is_stale(i, now)) r.live++;
            end
            default: ;
        endcase
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("MISMATCH word %0d %s: got %h expected %h", words_checked, what, got, want);
    endtask

    // results are stable at the falling edge
    always @(negedge i_clk) begin
        t_grant_res want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", 64'd1, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_flags_out !== want.flags) report_mismatch("flags_out", o_flags_out, want.flags);
                if (o_token_ok !== want.tok_ok) report_mismatch("token_ok", o_token_ok, want.tok_ok);
                if (o_allow_total !== want.allow_tot)
                    report_mismatch("allow_total", o_allow_total, want.allow_tot);
                if (o_deny_total !== want.deny_tot)
                    report_mismatch("deny_total", o_deny_total, want.deny_tot);
                if (o_live_entries !== want.live)
                    report_mismatch("live_entries", o_live_entries, want.live);
                words_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("keyed_grant_table_with_expiry test failed");
            $finish;
        end
    end

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_word(input logic [2:0] op, input logic [31:0] uid,
                             input logic [31:0] gfl, input logic [63:0] tok,
                             input logic [63:0] ttl, input logic [63:0] now);
        while (idle_on && $urandom_range(99) < 25) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_user_id <= uid;
        i_grant_flags <= gfl;
        i_token <= tok;
        i_ttl_ns <= ttl;
        i_now <= now;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
        grant_table_step(op, uid, gfl, tok, ttl, now);
        words_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] data);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MASTER) pm_master = data;
        else pm_freq = data[31:0];
    endtask

    task automatic test_directed();
        send_word(OP_QUERY, 32'd5, '0, '0, '0, 64'd10);
        send_word(OP_REVOKE, 32'd5, '0, '0, '0, 64'd10);
        send_word(OP_ALLOW, 32'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        send_word(OP_ALLOW, 32'hFFFF_FFFF, 32'h0000_0001, 64'h1234, 64'd1000000000, 64'd100);
        // merge: flags OR, zero token keeps the old one
        send_word(OP_ALLOW, 32'hFFFF_FFFF, 32'h8000_0000, '0, 64'd5, 64'd200);
        send_word(OP_CHECK, 32'hFFFF_FFFF, '0, 64'h1234, '0, 64'd300);
        send_word(OP_QUERY, 32'hFFFF_FFFF, '0, '0, '0, 64'd300);
        send_word(OP_STATS, '0, '0, '0, '0, 64'd300);
        // expired entry: query deactivates it
        send_word(OP_QUERY, 32'hFFFF_FFFF, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_ALLOW, 32'd7, 32'h5A5A_5A5A, 64'hBEEF, 64'd1000000000, 64'd0);
        send_word(OP_CHECK, 32'd7, '0, 64'hBEEF, '0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_CHECK, 32'd7, '0, 64'hBEEF, '0, 64'd0);
        // huge ttl and now: wrapping product and sum
        send_word(OP_ALLOW, 32'd9, 32'h1, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_STATS, '0, '0, '0, '0, 64'd5);
        send_word(OP_CHECK, 32'd0, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        send_word(OP_REVOKE, 32'd0, '0, '0, '0, '0);
        send_word(OP_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, '1);
        send_word(OP_SPARE_HI, 32'd9, 32'd1, 64'd1, 64'd1, 64'd1);
        send_word(OP_CLEAR, '0, '0, '0, '0, '0);
        send_word(OP_STATS, '0, '0, '0, '0, '0);
    endtask

    // fill all slots, overflow, free one and reuse it
    task automatic test_table_full();
        for (int i = 0; i < N_SLOTS; i++)
            send_word(OP_ALLOW, 32'd100 + i, i + 1, 64'd500 + i, '0, clock_now);
        send_word(OP_ALLOW, 32'd999, 32'd1, 64'd1, '0, clock_now);
        send_word(OP_REVOKE, 32'd105, '0, '0, '0, clock_now);
        send_word(OP_ALLOW, 32'd999, 32'd3, 64'd2, 64'd1, clock_now);
        send_word(OP_STATS, '0, '0, '0, '0, clock_now);
        send_word(OP_CLEAR, '0, '0, '0, '0, '0);
    endtask

    task automatic test_random(input int count);
        logic [2:0]  op;
        logic [31:0] uid, gfl;
        logic [63:0] tok, ttl, now;
        int          p;
        for (int k = 0; k < count; k++) begin
            if (k % 150 == 40) idle_on = 1'b0;
            if (k % 150 == 80) idle_on = 1'b1;
            p = $urandom_range(99);
            if (p < 35) op = OP_ALLOW;
            else if (p < 45) op = OP_REVOKE;
            else if (p < 47) op = OP_CLEAR;
            else if (p < 72) op = OP_QUERY;
            else if (p < 89) op = OP_CHECK;
            else if (p < 98) op = OP_STATS;
            else op = $urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI;
            uid = ($urandom_range(99) < 85) ? uid_pool[$urandom_range(5)] : $urandom;
            gfl = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
            p = $urandom_range(9);
            if (p < 7) tok = tok_pool[$urandom_range(3)];
            else if (p == 7) tok = '0;
            else if (p == 8) tok = pm_master;
            else tok = {$urandom, $urandom};
            p = $urandom_range(19);
            if (p < 6) ttl = '0;
            else if (p < 19) ttl = $urandom_range(2000000000, 1);
            else ttl = {$urandom, $urandom};
            clock_now += $urandom_range(5000000);
            p = $urandom_range(19);
            if (p == 0) now = {$urandom, $urandom};
            else if (p == 1) now = clock_now - $urandom_range(20000000);
            else now = clock_now;
            send_word(op, uid, gfl, tok, ttl, now);
        end
    endtask

    initial begin
        pm_master = '0;
        pm_freq = FREQ_RESET;
        for (int i = 0; i < N_SLOTS; i++) tbl_active[i] = 1'b0;
        tbl_used = 0;
        hits_allow = '0;
        hits_deny = '0;
        uid_pool = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom, 32'd42, 32'h8000_0001};
        for (int i = 0; i < 4; i++) tok_pool[i] = {$urandom, $urandom};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_reg(CFG_MASTER, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_FREQ, 64'h0000_0000_0000_0001);
        test_directed();
        test_table_full();
        write_reg(CFG_MASTER, tok_pool[0]);
        write_reg(CFG_FREQ, {$urandom, 32'd19200000});
        test_random(250);
        write_reg(CFG_MASTER, '0);
        write_reg(CFG_FREQ, 64'hFFFF_FFFF_FFFF_FFFF);
        test_random(150);
        write_reg(CFG_MASTER, {$urandom, $urandom});
        write_reg(CFG_FREQ, 64'd1000000000);
        test_table_full();
        test_random(250);
        drain_results();

        $display("Sent %0d command words over five register settings, checked %0d results,",
                 words_sent, words_checked);
        $display("covering merges, expiry, full table, master key and unused codes.");
        if (errors == 0) begin
            $display("keyed_grant_table_with_expiry test passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("keyed_grant_table_with_expiry test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
